// ----- rtl/ipcc_pkg.sv -----
// ipcc_pkg: shared types and constants for the ipv4 protocol classify counter
// no dependencies
`timescale 1ns / 1ps

package ipcc_pkg;

	localparam int LINK_HEADER_BYTES_DEF = 14;
	localparam int COUNT_WIDTH_DEF       = 32;
	localparam int POS_WIDTH             = 16;
	localparam int OUT_COUNT_WIDTH       = 32;

	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;
	localparam logic [7:0] PROTO_ICMP = 8'd1;

	localparam logic [3:0] IP_VERSION_4  = 4'd4;
	// 20 byte minimum header, in 32-bit words
	localparam logic [3:0] HDR_MIN_WORDS = 4'd5;
	localparam logic [POS_WIDTH-1:0] TCP_OFFSET_POS = POS_WIDTH'(12);

	typedef enum logic [1:0] {
		CLS_TCP   = 2'd0,
		CLS_UDP   = 2'd1,
		CLS_ICMP  = 2'd2,
		CLS_OTHER = 2'd3
	} class_t;

	typedef struct packed {
		class_t pkt_class;
		logic   invalid;
	} frame_sum_t;

endpackage

// ----- rtl/ipcc_parser.sv -----
// ipcc_parser: input register and per-frame header capture, classes a frame on its last byte
// depends on ipcc_pkg
`timescale 1ns / 1ps

module ipcc_parser import ipcc_pkg::*; #(
	parameter int LINK_HEADER_BYTES = LINK_HEADER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       sum_space,
	output logic       sum_valid,
	output frame_sum_t sum
);

	localparam logic [POS_WIDTH-1:0] IP_POS    = POS_WIDTH'(LINK_HEADER_BYTES);
	localparam logic [POS_WIDTH-1:0] PROTO_POS = POS_WIDTH'(LINK_HEADER_BYTES + 9);

	logic [7:0]           byte_s1;
	logic                 last_s1;
	logic                 valid_s1;
	logic                 advance;

	logic [POS_WIDTH-1:0] pos_q;
	logic [3:0]           ver_q, ihl_q, tcpoff_q;
	logic [7:0]           proto_q;
	logic [2:0]           seen_q;

	logic [3:0]           ver_d, ihl_d, tcpoff_d;
	logic [7:0]           proto_d;
	logic [2:0]           seen_d;
	logic [POS_WIDTH-1:0] tcp_pos;
	logic                 ip_bad;

	assign advance  = valid_s1 && (!last_s1 || sum_space);
	assign in_ready = !valid_s1 || advance;
	assign tcp_pos  = IP_POS + POS_WIDTH'({ihl_q, 2'b00}) + TCP_OFFSET_POS;

	always_comb begin
		ver_d    = ver_q;
		ihl_d    = ihl_q;
		proto_d  = proto_q;
		tcpoff_d = tcpoff_q;
		seen_d   = seen_q;
		if (pos_q == IP_POS) begin
			ver_d     = byte_s1[7:4];
			ihl_d     = byte_s1[3:0];
			seen_d[0] = 1'b1;
		end
		if (pos_q == PROTO_POS) begin
			proto_d   = byte_s1;
			seen_d[1] = 1'b1;
		end
		if (seen_q[0] && pos_q == tcp_pos) begin
			tcpoff_d  = byte_s1[7:4];
			seen_d[2] = 1'b1;
		end
	end

	assign ip_bad = (seen_d[1:0] != 2'b11) || (ihl_d < HDR_MIN_WORDS) ||
		(ver_d != IP_VERSION_4);

	always_comb begin
		sum.invalid   = ip_bad;
		sum.pkt_class = CLS_OTHER;
		if (!ip_bad) begin
			case (proto_d)
				PROTO_TCP: begin
					if (!seen_d[2] || tcpoff_d < HDR_MIN_WORDS) begin
						sum.invalid = 1'b1;
					end else begin
						sum.pkt_class = CLS_TCP;
					end
				end
				PROTO_UDP:  sum.pkt_class = CLS_UDP;
				PROTO_ICMP: sum.pkt_class = CLS_ICMP;
				default:    sum.pkt_class = CLS_OTHER;
			endcase
		end
	end

	assign sum_valid = advance && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			ver_q    <= '0;
			ihl_q    <= '0;
			proto_q  <= '0;
			tcpoff_q <= '0;
			seen_q   <= '0;
		end else if (advance) begin
			if (last_s1) begin
				pos_q    <= '0;
				ver_q    <= '0;
				ihl_q    <= '0;
				proto_q  <= '0;
				tcpoff_q <= '0;
				seen_q   <= '0;
			end else begin
				if (pos_q != '1) begin
					pos_q <= pos_q + 1'b1;
				end
				ver_q    <= ver_d;
				ihl_q    <= ihl_d;
				proto_q  <= proto_d;
				tcpoff_q <= tcpoff_d;
				seen_q   <= seen_d;
			end
		end
	end

endmodule

// ----- rtl/ipcc_counters.sv -----
// ipcc_counters: saturating class and frame counters with the result register
// depends on ipcc_pkg
`timescale 1ns / 1ps

module ipcc_counters import ipcc_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sum_valid,
	input  frame_sum_t                   sum,
	output logic                         sum_space,
	output logic                         out_valid,
	input  logic                         out_ready,
	output frame_sum_t                   out_sum,
	output logic [4:0][OUT_COUNT_WIDTH-1:0] out_counts
);

	localparam int EXT_W = (COUNT_WIDTH > OUT_COUNT_WIDTH) ? COUNT_WIDTH : OUT_COUNT_WIDTH;

	// entries 0..3 per class, entry 4 all frames
	logic [4:0][COUNT_WIDTH-1:0] cnt_q;
	logic [4:0][COUNT_WIDTH-1:0] cnt_d;
	logic                        out_valid_q;
	frame_sum_t                  sum_q;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		sat_inc = (v == '1) ? v : v + 1'b1;
	endfunction

	always_comb begin
		cnt_d = cnt_q;
		for (int i = 0; i < 4; i++) begin
			if (sum.pkt_class == class_t'(i)) begin
				cnt_d[i] = sat_inc(cnt_q[i]);
			end
		end
		cnt_d[4] = sat_inc(cnt_q[4]);
	end

	assign sum_space = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_sum   = sum_q;

	always_comb begin
		for (int i = 0; i < 5; i++) begin
			logic [EXT_W-1:0] ext;
			ext           = EXT_W'(cnt_q[i]);
			out_counts[i] = ext[OUT_COUNT_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (sum_valid) begin
				cnt_q <= cnt_d;
			end
			if (sum_space) begin
				out_valid_q <= sum_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sum_valid) begin
			sum_q <= sum;
		end
	end

endmodule

// ----- rtl/ipv4_protocol_classify_counter_top.sv -----
// ipv4_protocol_classify_counter_top: classifies ipv4 frames by l4 protocol and counts them
// depends on ipcc_pkg, ipcc_parser, ipcc_counters
//
// usage:
//   s_* takes one frame byte per transaction in tdata, tlast on the final byte
//   of each frame. m_* gives one result transaction per frame: tuser carries
//   the class (0 tcp, 1 udp, 2 icmp, 3 other) and the header invalid flag,
//   tdata the five counters after this frame was counted.
//   a last byte waits in the input register and moves on to the result register once it is free.
//   throughput: one byte per cycle while no frame end waits for the result register, set by the
//   single input register and the single result register; header capture needs only position compares.
//   counters saturate at all ones and show their low 32 bits.
//   reset clears the frame position, captured header fields and all counters;
//   the block takes bytes in the first cycle after reset.
//   when m_tready is low, the result is held; bytes that do not end a frame
//   keep flowing, and a frame end waits in the input register with s_tready
//   low until the result register frees.
`timescale 1ns / 1ps

module ipv4_protocol_classify_counter_top import ipcc_pkg::*; #(
	parameter int LINK_HEADER_BYTES = LINK_HEADER_BYTES_DEF,
	parameter int COUNT_WIDTH       = COUNT_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // frame_byte
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [159:0] m_tdata,  // tcp_total, udp_total, icmp_total, other_total, frame_total
	output logic [2:0]   m_tuser   // packet_class, header_invalid
);

	logic       sum_valid;
	logic       sum_space;
	frame_sum_t sum;
	frame_sum_t out_sum;
	logic [4:0][OUT_COUNT_WIDTH-1:0] out_counts;

	ipcc_parser #(
		.LINK_HEADER_BYTES(LINK_HEADER_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.sum_space (sum_space),
		.sum_valid (sum_valid),
		.sum       (sum)
	);

	ipcc_counters #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_counters (
		.clk        (clk),
		.arst_n     (arst_n),
		.sum_valid  (sum_valid),
		.sum        (sum),
		.sum_space  (sum_space),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_sum    (out_sum),
		.out_counts (out_counts)
	);

	assign m_tdata = out_counts;
	assign m_tuser = {out_sum.invalid, out_sum.pkt_class};

endmodule

// ----- rtl/ipcc_checker.sv -----
// ipcc_checker: port-level checks on the classify counter result channel, bound to the top level
// depends on ipcc_pkg, ipv4_protocol_classify_counter_top
`timescale 1ns / 1ps

module ipcc_checker import ipcc_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [159:0] m_tdata,
	input logic [2:0]   m_tuser
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// invalid header always classes as other
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == CLS_OTHER)
		else $error("invalid frame not classed other");

	// a tcp result has been counted
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == CLS_TCP |-> m_tdata[31:0] != '0)
		else $error("tcp result with zero tcp count");

	// every result has been counted in the frame total
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[159:128] != '0)
		else $error("result with zero frame count");

endmodule

bind ipv4_protocol_classify_counter_top ipcc_checker u_ipcc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ----- dv/tb_ipv4_protocol_classify_counter_top.sv -----
// tb_ipv4_protocol_classify_counter_top: self-checking bench for the ipv4 protocol classify counter
// depends on ipcc_pkg and ipv4_protocol_classify_counter_top; directed and random frames
// go in byte by byte, and each result transaction is checked against an in-bench classifier
`timescale 1ns / 1ps

module tb_ipv4_protocol_classify_counter_top import ipcc_pkg::*;;

	localparam int LINK         = LINK_HEADER_BYTES_DEF;
	localparam int RANDOM_ITEMS = 1100;
	localparam int RANDOM_MIN   = 16;
	localparam int QUIET_TAIL   = 300;
	localparam int HOLD_AT      = 25;
	localparam int LONG_HOLD    = 400;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         drain;
	} byte_item_t;

	typedef struct packed {
		class_t         cls;
		logic           invalid;
		logic [159:0]   totals;
	} frame_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [159:0] m_tdata;
	logic [2:0]   m_tuser;

	// classifier state, mirrors the block
	logic [15:0] cur_pos;
	logic [3:0]  hdr_ver;
	logic [3:0]  hdr_words;
	logic [7:0]  hdr_proto;
	logic [3:0]  tcp_words;
	logic [2:0]  got_fields;
	logic [31:0] class_cnt [4];
	logic [31:0] frame_cnt;

	byte_item_t    byte_q[$];
	frame_result_t result_q[$];

	string total_name [5] = '{"tcp_total", "udp_total", "icmp_total", "other_total",
		"frame_total"};

	int  errors;
	int  cycles;
	int  results_seen;
	int  items_queued;
	int  frames_queued;
	int  send_gap;
	int  rcv_gap;
	int  hold_left;
	bit  in_fire;
	bit  quiet;

	ipv4_protocol_classify_counter_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	// take one frame byte, queue the result when it ends a frame
	function void classify_byte(input logic [7:0] b, input logic last);
		frame_result_t r;
		class_t        cls;
		logic          bad;
		if (int'(cur_pos) == LINK) begin
			hdr_ver       = b[7:4];
			hdr_words     = b[3:0];
			got_fields[0] = 1'b1;
		end
		if (int'(cur_pos) == LINK + 9) begin
			hdr_proto     = b;
			got_fields[1] = 1'b1;
		end
		if (got_fields[0] && int'(cur_pos) == LINK + 4 * int'(hdr_words) + 12) begin
			tcp_words     = b[7:4];
			got_fields[2] = 1'b1;
		end
		if (cur_pos != 16'hFFFF)
			cur_pos++;
		if (!last)
			return;
		bad = (got_fields[1:0] != 2'b11) || (hdr_words < HDR_MIN_WORDS) ||
			(hdr_ver != IP_VERSION_4);
		if (bad)
			cls = CLS_OTHER;
		else if (hdr_proto == PROTO_TCP) begin
			if (!got_fields[2] || tcp_words < HDR_MIN_WORDS) begin
				bad = 1'b1;
				cls = CLS_OTHER;
			end else
				cls = CLS_TCP;
		end else if (hdr_proto == PROTO_UDP)
			cls = CLS_UDP;
		else if (hdr_proto == PROTO_ICMP)
			cls = CLS_ICMP;
		else
			cls = CLS_OTHER;
		class_cnt[cls] = sat_inc(class_cnt[cls]);
		frame_cnt      = sat_inc(frame_cnt);
		r.cls     = cls;
		r.invalid = bad;
		r.totals  = {frame_cnt, class_cnt[CLS_OTHER], class_cnt[CLS_ICMP],
			class_cnt[CLS_UDP], class_cnt[CLS_TCP]};
		result_q.push_back(r);
		cur_pos    = '0;
		hdr_ver    = '0;
		hdr_words  = '0;
		hdr_proto  = '0;
		tcp_words  = '0;
		got_fields = '0;
	endfunction

	function void check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// fill < 0 gives random filler bytes, else every filler byte is that value
	task automatic queue_frame(input logic [3:0] ver, input logic [3:0] words,
		input logic [7:0] proto, input logic [3:0] tcp_off, input int len, input int fill,
		input bit drain);
		byte_item_t it;
		for (int i = 0; i < len; i++) begin
			it.data = (fill < 0) ? 8'($urandom) : 8'(fill);
			if (i == LINK)
				it.data = {ver, words};
			if (i == LINK + 9)
				it.data = proto;
			if (i == LINK + 4 * int'(words) + 12)
				it.data[7:4] = tcp_off;
			it.last  = (i == len - 1);
			it.drain = drain && (i == 0);
			byte_q.push_back(it);
		end
		items_queued += len;
		frames_queued++;
	endtask

	initial begin
		logic [3:0] ver;
		logic [3:0] words;
		logic [3:0] toff;
		logic [7:0] proto;
		int         full;
		int         len;
		int         rnd_start;
		int         rnd_frames;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		cur_pos    = '0;
		hdr_ver    = '0;
		hdr_words  = '0;
		hdr_proto  = '0;
		tcp_words  = '0;
		got_fields = '0;
		frame_cnt  = '0;
		foreach (class_cnt[i])
			class_cnt[i] = '0;

		// short frames ending before, on and after each captured field
		queue_frame(4, 5, PROTO_UDP, 5, 1, -1, 0);
		queue_frame(4, 5, PROTO_UDP, 5, LINK, -1, 0);
		queue_frame(4, 5, PROTO_UDP, 5, LINK + 1, -1, 0);
		queue_frame(4, 5, PROTO_UDP, 5, LINK + 10, -1, 0);
		queue_frame(4, 5, PROTO_TCP, 5, LINK + 33, -1, 0);
		queue_frame(4, 5, PROTO_TCP, 5, LINK + 32, -1, 0);
		// header length and data offset extremes
		queue_frame(4, 15, PROTO_TCP, 15, LINK + 80, -1, 0);
		queue_frame(4, 5, PROTO_TCP, 4, LINK + 40, -1, 0);
		queue_frame(4, 6, PROTO_TCP, 0, LINK + 44, -1, 0);
		queue_frame(4, 5, PROTO_ICMP, 5, LINK + 28, -1, 0);
		queue_frame(4, 5, 8'hFF, 5, LINK + 28, -1, 0);
		queue_frame(4, 5, 8'h00, 5, LINK + 28, -1, 0);
		queue_frame(6, 5, PROTO_UDP, 5, LINK + 28, -1, 0);
		queue_frame(4, 4, PROTO_UDP, 5, LINK + 28, -1, 0);
		queue_frame(4, 0, PROTO_TCP, 5, LINK + 28, -1, 0);
		queue_frame(4'hF, 4'hF, 8'hFF, 4'hF, 60, 8'hFF, 0);
		queue_frame(4, 5, PROTO_UDP, 5, LINK + 28, 0, 0);

		rnd_start  = items_queued;
		rnd_frames = 0;
		while (items_queued - rnd_start < RANDOM_ITEMS || rnd_frames < RANDOM_MIN) begin
			ver = ($urandom_range(0, 11) == 0) ? 4'($urandom) : IP_VERSION_4;
			case ($urandom_range(0, 9))
				0: words = 4'($urandom_range(0, 15));
				1, 2, 3, 4: words = 4'd5;
				default: words = 4'($urandom_range(6, 15));
			endcase
			case ($urandom_range(0, 5))
				0, 1: proto = PROTO_TCP;
				2: proto = PROTO_UDP;
				3: proto = PROTO_ICMP;
				4: proto = 8'($urandom);
				default: proto = 8'($urandom_range(0, 20));
			endcase
			toff = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 4)) :
				4'($urandom_range(5, 15));
			full = LINK + 4 * int'(words) + 20 + $urandom_range(0, 12);
			len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, full) : full;
			queue_frame(ver, words, proto, toff, len, -1, rnd_frames == 10);
			rnd_frames++;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (byte_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// byte driver
	always @(negedge clk) begin
		if (arst_n) begin
			quiet = byte_q.size() < QUIET_TAIL;
			if (!s_tvalid || in_fire) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (byte_q.size() == 0)
					s_tvalid <= 1'b0;
				else if (byte_q[0].drain && result_q.size() != 0)
					s_tvalid <= 1'b0;
				else begin
					s_tdata  <= byte_q[0].data;
					s_tlast  <= byte_q[0].last;
					s_tvalid <= 1'b1;
					void'(byte_q.pop_front());
					if (!quiet && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 10);
				end
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rcv_gap > 0) begin
				rcv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!quiet && $urandom_range(0, 4) == 0)
					rcv_gap = $urandom_range(1, 10);
			end
		end
	end

	// transaction monitor on both sides
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual class %0d",
						$time, m_tuser[1:0]);
					errors++;
				end else begin
					want = result_q.pop_front();
					check_field("packet_class", 32'(want.cls), 32'(m_tuser[1:0]));
					check_field("header_invalid", 32'(want.invalid), 32'(m_tuser[2]));
					for (int k = 0; k < 5; k++)
						check_field(total_name[k], want.totals[32*k +: 32],
							m_tdata[32*k +: 32]);
				end
				results_seen++;
				if (results_seen == HOLD_AT)
					hold_left = LONG_HOLD;
			end
			in_fire = s_tvalid && s_tready;
			if (in_fire)
				classify_byte(s_tdata, s_tlast);
		end
	end

endmodule
